// ===== design/cbls_pkg.sv =====
// Shared types, constants and helpers for the comment blanker and line splicer.
package cbls_pkg;

   // Whitespace held after a backslash
   localparam int SPACE_DEPTH = 16;
   localparam int CNT_W       = $clog2(SPACE_DEPTH + 1);
   localparam int IDX_W       = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
   localparam int STEP_W      = $clog2(SPACE_DEPTH + 2);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Most results one command of the emit kind carries
   localparam int MAX_EMIT    = 3;

   // Character codes
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef enum logic [1:0] {
      OUT_CHAR   = 2'd0,
      OUT_MARK   = 2'd1,
      OUT_EOF    = 2'd2,
      OUT_NOTICE = 2'd3
   } out_kind_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_OPEN_CMT   = 2'd1,
      ST_BSLASH_END = 2'd2,
      ST_WS_OVF     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_EMIT  = 2'd0,
      CMD_STORE = 2'd1,
      CMD_FLUSH = 2'd2
   } cmd_op_type;

   typedef struct packed {
      out_kind_type kind;
      logic [7:0]   ch;
      status_type   status;
   } result_type;

   // One command per accepted transaction that produces work
   typedef struct packed {
      cmd_op_type              op;
      logic [1:0]              n;      // result count for emit
      result_type [MAX_EMIT-1:0] res;  // emit results in order
      logic [CNT_W-1:0]        count;  // flush: buffered whitespace
      logic [IDX_W-1:0]        idx;    // store: buffer slot
      logic [7:0]              ch;     // store byte or flush final char
   } cmd_type;

   function automatic result_type mk_char(input logic [7:0] c);
      result_type r;
      r.kind   = OUT_CHAR;
      r.ch     = c;
      r.status = ST_OK;
      return r;
   endfunction

   function automatic result_type mk_ctrl(input out_kind_type k, input status_type s);
      result_type r;
      r.kind   = k;
      r.ch     = 8'd0;
      r.status = s;
      return r;
   endfunction

   // Append one result to an emit command
   function automatic cmd_type add_res(input cmd_type c, input result_type r);
      cmd_type o;
      o = c;
      case (c.n)
         2'd0: begin
            o.res[0] = r;
         end
         2'd1: begin
            o.res[1] = r;
         end
         default: begin
            o.res[2] = r;
         end
      endcase
      o.n = c.n + 2'd1;
      return o;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
             (c == CH_FF) || (c == CH_CR);
   endfunction

endpackage

// ===== design/comment_blanker_line_splicer.sv =====
// Top level of the comment blanker and line splicer.
// Input channel req_*: one transaction per source character (req_tuser = 0,
// byte in req_tdata) or end of file (req_tuser = 1). Result channel rsp_*:
// characters, line markers, end of file and notices; rsp_tlast marks the
// last result produced by one input transaction. Some inputs produce none.
// A front end classifies each character combinationally and queues at most one
// command (up to four are held); a back end turns commands into results through a
// registered output stage.
// Throughput: one input per cycle while each yields at most one result and
// rsp_tready stays high; an input with several results holds the back end until
// all are out. A backslash run that is not a splice yields the backslash, the
// buffered whitespace read from the buffer memory one byte a cycle while
// rsp_tready is high, and the final character; each buffered byte also takes a
// store command in the back end.
// Reset clears the lexical state, the queue and the output stage. When the
// receiver holds rsp_tready low the result stays put, the queue fills and
// req_tready drops once four commands are waiting.
module comment_blanker_line_splicer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_char, [9:8] status, [15:10] zero
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   output logic        rsp_tlast    // last_of_run
);
   import cbls_pkg::*;

   logic       cmd_valid, queue_full, head_valid, pop;
   cmd_type    cmd, head;
   result_type res;

   cbls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_kind    (req_tuser),
      .in_ch      (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .queue_full (queue_full)
   );

   cbls_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_valid),
      .push_data  (cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   cbls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_res    (res),
      .out_last   (rsp_tlast)
   );

   // Pack the result fields
   assign rsp_tdata = {6'd0, res.status, res.ch};
   assign rsp_tuser = res.kind;

endmodule

// ===== design/cbls_front.sv =====
// Front end: accepts characters, tracks lexical state and issues back-end commands.
module cbls_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_kind,
   input  logic [7:0]        in_ch,
   output logic              cmd_valid,
   output cbls_pkg::cmd_type cmd,
   input  logic              queue_full
);
   import cbls_pkg::*;

   typedef enum logic [1:0] {
      MODE_NORMAL    = 2'd0,
      MODE_SLASH     = 2'd1,
      MODE_COMMENT   = 2'd2,
      MODE_BACKSLASH = 2'd3
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic             star_ff, star_in;
   logic             splice_ff, splice_in;
   logic [CNT_W-1:0] space_count_ff, space_count_in;

   logic    accepted;
   logic    push;
   logic    do_plain;
   cmd_type c;

   assign in_ready = !queue_full;
   assign accepted = in_valid && !queue_full;

   // Classify the character and build the command
   always_comb begin
      mode_in        = mode_ff;
      star_in        = star_ff;
      splice_in      = splice_ff;
      space_count_in = space_count_ff;
      push           = 1'b0;
      do_plain       = 1'b0;
      c              = '0;
      c.op           = CMD_EMIT;

      if (in_kind) begin
         case (mode_ff)
            MODE_SLASH: begin
               c = add_res(c, mk_char(CH_SLASH));
            end
            MODE_COMMENT: begin
               c = add_res(c, mk_ctrl(OUT_NOTICE, ST_OPEN_CMT));
            end
            MODE_BACKSLASH: begin
               c = add_res(c, mk_ctrl(OUT_NOTICE, ST_BSLASH_END));
            end
            default: begin
            end
         endcase
         c              = add_res(c, mk_ctrl(OUT_EOF, ST_OK));
         mode_in        = MODE_NORMAL;
         star_in        = 1'b0;
         splice_in      = 1'b0;
         space_count_in = '0;
      end else begin
         case (mode_ff)
            MODE_NORMAL: begin
               do_plain = 1'b1;
            end
            MODE_SLASH: begin
               if (in_ch == CH_STAR) begin
                  c       = add_res(c, mk_char(CH_SPACE));
                  c       = add_res(c, mk_char(CH_SPACE));
                  mode_in = MODE_COMMENT;
                  star_in = 1'b0;
               end else begin
                  c        = add_res(c, mk_char(CH_SLASH));
                  mode_in  = MODE_NORMAL;
                  do_plain = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (star_ff && in_ch == CH_SLASH) begin
                  c       = add_res(c, mk_char(CH_SPACE));
                  mode_in = MODE_NORMAL;
                  star_in = 1'b0;
               end else begin
                  c       = add_res(c, mk_char((in_ch == CH_NL) ? CH_NL : CH_SPACE));
                  star_in = (in_ch == CH_STAR);
               end
            end
            default: begin
               // After a backslash: buffer blanks (notice when full), splice on newline, else flush
               if (is_blank(in_ch)) begin
                  if (space_count_ff < CNT_W'(SPACE_DEPTH)) begin
                     c.op           = CMD_STORE;
                     c.idx          = space_count_ff[IDX_W-1:0];
                     c.ch           = in_ch;
                     push           = 1'b1;
                     space_count_in = space_count_ff + CNT_W'(1);
                  end else begin
                     c = add_res(c, mk_ctrl(OUT_NOTICE, ST_WS_OVF));
                  end
               end else if (in_ch == CH_NL) begin
                  splice_in      = 1'b1;
                  space_count_in = '0;
                  mode_in        = MODE_NORMAL;
               end else begin
                  c.op           = CMD_FLUSH;
                  c.count        = space_count_ff;
                  c.ch           = in_ch;
                  push           = 1'b1;
                  space_count_in = '0;
                  mode_in        = MODE_NORMAL;
               end
            end
         endcase

         // Plain character outside comments
         if (do_plain) begin
            if (in_ch == CH_SLASH) begin
               mode_in = MODE_SLASH;
            end else if (in_ch == CH_BSLASH) begin
               mode_in        = MODE_BACKSLASH;
               space_count_in = '0;
            end else begin
               c = add_res(c, mk_char(in_ch));
               if (in_ch == CH_NL && splice_ff) begin
                  c         = add_res(c, mk_ctrl(OUT_MARK, ST_OK));
                  splice_in = 1'b0;
               end
            end
         end
      end

      if (c.op == CMD_EMIT) begin
         push = (c.n != 2'd0);
      end
   end

   assign cmd_valid = accepted && push;
   assign cmd       = c;

   // Hold lexical state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_NORMAL;
         star_ff        <= 1'b0;
         splice_ff      <= 1'b0;
         space_count_ff <= '0;
      end else if (accepted) begin
         mode_ff        <= mode_in;
         star_ff        <= star_in;
         splice_ff      <= splice_in;
         space_count_ff <= space_count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      space_count_ff <= CNT_W'(SPACE_DEPTH))
      else $error("whitespace count past buffer depth");

   a_star_in_comment: assert property (@(posedge clock) disable iff (reset)
      star_ff |-> (mode_ff == MODE_COMMENT))
      else $error("star flag set outside a comment");

endmodule

// ===== design/cbls_fifo.sv =====
// Short command queue decoupling the front end from the back end.
module cbls_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cbls_pkg::cmd_type push_data,
   output logic              full,
   output logic              head_valid,
   output cbls_pkg::cmd_type head,
   input  logic              pop
);
   import cbls_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10: begin
            count_in = count_ff + QCNT_W'(1);
         end
         2'b01: begin
            count_in = count_ff - QCNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the command
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count past depth");

endmodule

// ===== design/cbls_back.sv =====
// Back end: runs queued commands, owns the whitespace buffer and the result register.
module cbls_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  cbls_pkg::cmd_type    head,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cbls_pkg::result_type out_res,
   output logic                 out_last
);
   import cbls_pkg::*;

   logic [7:0]        space_mem [SPACE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [STEP_W-1:0] step_ff, step_in;

   result_type rsp_res_ff, res_in;
   logic       rsp_valid_ff;
   logic       rsp_last_ff, last_in;

   logic             can_load, load, rd_en, wr_en;
   logic [STEP_W-1:0] count_ext;

   assign can_load  = !rsp_valid_ff || out_ready;
   assign count_ext = STEP_W'(head.count);

   // Sequence results for the head command
   always_comb begin
      pop     = 1'b0;
      load    = 1'b0;
      rd_en   = 1'b0;
      wr_en   = 1'b0;
      res_in  = '0;
      last_in = 1'b0;
      step_in = step_ff;
      if (head_valid) begin
         case (head.op)
            CMD_STORE: begin
               wr_en = 1'b1;
               pop   = 1'b1;
            end
            CMD_EMIT: begin
               if (can_load) begin
                  load = 1'b1;
                  case (step_ff[1:0])
                     2'd0: begin
                        res_in = head.res[0];
                     end
                     2'd1: begin
                        res_in = head.res[1];
                     end
                     default: begin
                        res_in = head.res[2];
                     end
                  endcase
                  last_in = (step_ff == STEP_W'(head.n - 2'd1));
                  if (last_in) begin
                     pop     = 1'b1;
                     step_in = '0;
                  end else begin
                     step_in = step_ff + STEP_W'(1);
                  end
               end
            end
            CMD_FLUSH: begin
               // Backslash, buffered blanks, then the closing character
               if (can_load) begin
                  load  = 1'b1;
                  rd_en = (step_ff < STEP_W'(SPACE_DEPTH));
                  if (step_ff == '0) begin
                     res_in  = mk_char(CH_BSLASH);
                     step_in = step_ff + STEP_W'(1);
                  end else if (step_ff <= count_ext) begin
                     res_in  = mk_char(rd_data_ff);
                     step_in = step_ff + STEP_W'(1);
                  end else begin
                     res_in  = mk_char(head.ch);
                     last_in = 1'b1;
                     pop     = 1'b1;
                     step_in = '0;
                  end
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   // Whitespace buffer, registered read one step ahead
   always_ff @(posedge clock) begin
      if (wr_en) begin
         space_mem[head.idx] <= head.ch;
      end
      if (rd_en) begin
         rd_data_ff <= space_mem[step_ff[IDX_W-1:0]];
      end
   end

   // Hold the step counter and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_res_ff  <= res_in;
         rsp_last_ff <= last_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_res   = rsp_res_ff;
   assign out_last  = rsp_last_ff;

   a_step_needs_head: assert property (@(posedge clock) disable iff (reset)
      (step_ff != '0) |-> head_valid)
      else $error("step counter busy with no command");

   a_emit_step_range: assert property (@(posedge clock) disable iff (reset)
      (head_valid && head.op == CMD_EMIT) |-> (step_ff < STEP_W'(head.n)))
      else $error("emit step past result count");

endmodule
